// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; empty bodies under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRFG_ASSERT_HOLD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define CRFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CRFG_ASSERT_HOLD(lbl, clk, rstn, prop)
`define CRFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/crfg_pkg.sv =====
// Shared types and codes for the clipped rectangle fill grid.
`timescale 1ns / 1ps
package crfg_pkg;

  typedef enum logic [1:0] {
    FUNC_FILL  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CODE_SPACE = 3'd0,
    CODE_PLUS  = 3'd1,
    CODE_DASH  = 3'd2,
    CODE_BAR   = 3'd3,
    CODE_STAR  = 3'd4
  } code_t;

  localparam int unsigned XY_W  = 8;
  localparam int unsigned EXT_W = 7;
  localparam int unsigned RC_W  = 6;
  localparam int unsigned SUM_W = 9;  // signed origin plus extent

endpackage

// ===== rtl/core/clipped_rectangle_fill_grid.sv =====
// Top level: mark grid with box fill, clear and cell read.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  func, origin_x/y, box_width/height, read_row/col
//   out_     output     out_valid/out_stall cell_code, done_func
//
// One item per cycle while the output is not stalled; each item passes the input register, then the result register.
// Marks live in ROWS x COLS flip-flops, so a box sets all its cells in a single register update.
// Synchronous active-low reset clears the valids and every mark at once.
// A stalled output holds the result; the input stalls only when both stages are full
// and the output is stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clipped_rectangle_fill_grid #(
  parameter int ROWS  = 21,
  parameter int COLS  = 51,
  parameter int PITCH = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic signed [crfg_pkg::XY_W-1:0]  in_origin_x,
  input  logic signed [crfg_pkg::XY_W-1:0]  in_origin_y,
  input  logic [crfg_pkg::EXT_W-1:0]        in_box_width,
  input  logic [crfg_pkg::EXT_W-1:0]        in_box_height,
  input  logic [crfg_pkg::RC_W-1:0]         in_read_row,
  input  logic [crfg_pkg::RC_W-1:0]         in_read_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_cell_code,
  output logic [1:0]                        out_done_func
);

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int SPAN = 1 << crfg_pkg::RC_W;

  // input register
  logic                              s1_valid_r, s1_valid_nxt;
  crfg_pkg::func_t                   s1_func_r;
  logic signed [crfg_pkg::XY_W-1:0]  s1_origin_x_r;
  logic signed [crfg_pkg::XY_W-1:0]  s1_origin_y_r;
  logic [crfg_pkg::EXT_W-1:0]        s1_box_width_r;
  logic [crfg_pkg::EXT_W-1:0]        s1_box_height_r;
  logic [crfg_pkg::RC_W-1:0]         s1_read_row_r;
  logic [crfg_pkg::RC_W-1:0]         s1_read_col_r;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  crfg_pkg::code_t                   out_code_r, out_code_nxt;
  crfg_pkg::func_t                   out_func_r;

  logic [COLS-1:0]                   marks_r [ROWS];

  logic                              out_free;
  logic                              s1_adv;
  logic                              in_acc;
  logic [ROWS-1:0]                   row_mask;
  logic [COLS-1:0]                   col_mask;
  logic [SPAN-1:0]                   row_line;
  logic [SPAN-1:0]                   col_line;
  logic                              rd_in_grid;
  logic [COLS-1:0]                   rd_row_bits;
  logic                              rd_mark;
  logic                              rl, cl;
  logic                              any_mark;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  crfg_box_mask #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_mask (
    .origin_x   (s1_origin_x_r),
    .origin_y   (s1_origin_y_r),
    .box_width  (s1_box_width_r),
    .box_height (s1_box_height_r),
    .row_mask   (row_mask),
    .col_mask   (col_mask)
  );

  // ruled background lines, folded to constants
  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      row_line[i] = ((i % PITCH) == 0);
      col_line[i] = ((i % PITCH) == 0);
    end
  end

  assign rd_in_grid  = ({1'b0, s1_read_row_r} < (crfg_pkg::RC_W + 1)'(ROWS)) &&
                       ({1'b0, s1_read_col_r} < (crfg_pkg::RC_W + 1)'(COLS));
  assign rd_row_bits = marks_r[s1_read_row_r[RW-1:0]];
  assign rd_mark     = rd_row_bits[s1_read_col_r[CW-1:0]];
  assign rl          = row_line[s1_read_row_r];
  assign cl          = col_line[s1_read_col_r];

  always_comb begin
    out_code_nxt = crfg_pkg::CODE_SPACE;
    if (s1_func_r == crfg_pkg::FUNC_READ && rd_in_grid) begin
      if (rd_mark)      out_code_nxt = crfg_pkg::CODE_STAR;
      else if (rl && cl) out_code_nxt = crfg_pkg::CODE_PLUS;
      else if (rl)      out_code_nxt = crfg_pkg::CODE_DASH;
      else if (cl)      out_code_nxt = crfg_pkg::CODE_BAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r       <= crfg_pkg::func_t'(in_func);
      s1_origin_x_r   <= in_origin_x;
      s1_origin_y_r   <= in_origin_y;
      s1_box_width_r  <= in_box_width;
      s1_box_height_r <= in_box_height;
      s1_read_row_r   <= in_read_row;
      s1_read_col_r   <= in_read_col;
    end
    if (s1_adv) begin
      out_code_r <= out_code_nxt;
      out_func_r <= s1_func_r;
    end
  end

  // marks change at the edge the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) marks_r[i] <= '0;
    end else if (s1_adv) begin
      case (s1_func_r)
        crfg_pkg::FUNC_FILL: begin
          for (int i = 0; i < ROWS; i++)
            if (row_mask[i]) marks_r[i] <= marks_r[i] | col_mask;
        end
        crfg_pkg::FUNC_CLEAR: begin
          for (int i = 0; i < ROWS; i++) marks_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    any_mark = 1'b0;
    for (int i = 0; i < ROWS; i++) any_mark = any_mark | (|marks_r[i]);
  end

  assign out_valid     = out_valid_r;
  assign out_cell_code = out_code_r;
  assign out_done_func = out_func_r;

  `CRFG_ASSERT_NEXT(a_clear_empties, clk, rst_n,
                    s1_adv && s1_func_r == crfg_pkg::FUNC_CLEAR, !any_mark)
  `CRFG_ASSERT_HOLD(a_code_only_read, clk, rst_n,
                    (out_valid_r && out_func_r != crfg_pkg::FUNC_READ) |->
                    out_code_r == crfg_pkg::CODE_SPACE)
  `CRFG_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_func_r))

endmodule

// ===== rtl/core/crfg_box_mask.sv =====
// Clipped row and column range masks for one box item.
`timescale 1ns / 1ps
module crfg_box_mask #(
  parameter int ROWS = 21,
  parameter int COLS = 51
) (
  input  logic signed [crfg_pkg::XY_W-1:0]  origin_x,
  input  logic signed [crfg_pkg::XY_W-1:0]  origin_y,
  input  logic        [crfg_pkg::EXT_W-1:0] box_width,
  input  logic        [crfg_pkg::EXT_W-1:0] box_height,
  output logic        [ROWS-1:0]            row_mask,  // indexed from the top
  output logic        [COLS-1:0]            col_mask
);

  logic signed [crfg_pkg::SUM_W-1:0] x_lo;
  logic signed [crfg_pkg::SUM_W-1:0] x_hi;
  logic signed [crfg_pkg::SUM_W-1:0] y_lo;
  logic signed [crfg_pkg::SUM_W-1:0] y_hi;

  // Clipping falls out of the range compare: [lo, hi) against each cell.
  assign x_lo = crfg_pkg::SUM_W'(origin_x);
  assign y_lo = crfg_pkg::SUM_W'(origin_y);
  assign x_hi = x_lo + $signed({2'b00, box_width});
  assign y_hi = y_lo + $signed({2'b00, box_height});

  always_comb begin
    logic signed [crfg_pkg::SUM_W-1:0] pos;
    pos = '0;
    for (int c = 0; c < COLS; c++) begin
      pos = crfg_pkg::SUM_W'(c);
      col_mask[c] = (pos >= x_lo) && (pos < x_hi);
    end
  end

  always_comb begin
    logic signed [crfg_pkg::SUM_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < ROWS; i++) begin
      pos = crfg_pkg::SUM_W'(ROWS - 1 - i);  // row counted from the bottom
      row_mask[i] = (pos >= y_lo) && (pos < y_hi);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the clipped rectangle fill grid: box fill, clear and cell read.
`timescale 1ns / 1ps
module tb_top;

  localparam int GRID_ROWS  = 21;
  localparam int GRID_COLS  = 51;
  localparam int GRID_PITCH = 5;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    crfg_pkg::func_t                  func;
    logic signed [crfg_pkg::XY_W-1:0] ox;
    logic signed [crfg_pkg::XY_W-1:0] oy;
    logic [crfg_pkg::EXT_W-1:0]       w;
    logic [crfg_pkg::EXT_W-1:0]       h;
    logic [crfg_pkg::RC_W-1:0]        row;
    logic [crfg_pkg::RC_W-1:0]        col;
  } grid_item_t;

  typedef struct {
    crfg_pkg::code_t code;
    crfg_pkg::func_t func;
  } cell_result_t;

  class mark_grid_scoreboard;
    bit           marks [GRID_ROWS][GRID_COLS];
    cell_result_t expected_results[$];
    int           errors;

    function void fill_box(int x, int y, int w, int h);
      int r, c;
      // every clip applies on its own
      if (x < 0) begin
        w += x;
        x = 0;
      end
      if (y < 0) begin
        h += y;
        y = 0;
      end
      if (x > GRID_COLS - 1) w = 0;
      if (y > GRID_ROWS - 1) h = 0;
      if (x + w > GRID_COLS) w = GRID_COLS - x;
      if (y + h > GRID_ROWS) h = GRID_ROWS - y;
      if (w <= 0 || h <= 0) return;
      for (r = y; r < y + h; r++)
        for (c = x; c < x + w; c++)
          marks[GRID_ROWS - 1 - r][c] = 1'b1;
    endfunction

    function crfg_pkg::code_t code_at(int row, int col);
      bit on_row, on_col;
      if (row >= GRID_ROWS || col >= GRID_COLS) return crfg_pkg::CODE_SPACE;
      if (marks[row][col]) return crfg_pkg::CODE_STAR;
      on_row = (row % GRID_PITCH) == 0;
      on_col = (col % GRID_PITCH) == 0;
      if (on_row && on_col) return crfg_pkg::CODE_PLUS;
      if (on_row) return crfg_pkg::CODE_DASH;
      if (on_col) return crfg_pkg::CODE_BAR;
      return crfg_pkg::CODE_SPACE;
    endfunction

    function void note_item(grid_item_t it);
      cell_result_t res;
      res.code = crfg_pkg::CODE_SPACE;
      res.func = it.func;
      case (it.func)
        crfg_pkg::FUNC_FILL:  fill_box(int'(it.ox), int'(it.oy), int'(it.w), int'(it.h));
        crfg_pkg::FUNC_CLEAR: foreach (marks[r, c]) marks[r][c] = 1'b0;
        crfg_pkg::FUNC_READ:  res.code = code_at(int'(it.row), int'(it.col));
        default:    ;
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [2:0] code, logic [1:0] func);
      cell_result_t res;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected item code=%0d func=%0d", $realtime, code, func);
        return;
      end
      res = expected_results.pop_front();
      if (code !== res.code || func !== res.func) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch cell_code exp %0d got %0d, done_func exp %0d got %0d",
                   $realtime, res.code, code, res.func, func);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic signed [crfg_pkg::XY_W-1:0] in_origin_x = '0;
  logic signed [crfg_pkg::XY_W-1:0] in_origin_y = '0;
  logic [crfg_pkg::EXT_W-1:0] in_box_width = '0;
  logic [crfg_pkg::EXT_W-1:0] in_box_height = '0;
  logic [crfg_pkg::RC_W-1:0] in_read_row = '0;
  logic [crfg_pkg::RC_W-1:0] in_read_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_cell_code;
  logic [1:0] out_done_func;

  mark_grid_scoreboard board = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;

  clipped_rectangle_fill_grid #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS),
    .PITCH(GRID_PITCH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_origin_x  (in_origin_x),
    .in_origin_y  (in_origin_y),
    .in_box_width (in_box_width),
    .in_box_height(in_box_height),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cell_code(out_cell_code),
    .out_done_func(out_done_func)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_cell_code, out_done_func);
  end

  function automatic grid_item_t make_item(crfg_pkg::func_t f, int x, int y, int w, int h,
                                           int r, int c);
    grid_item_t it;
    it.func = f;
    it.ox   = crfg_pkg::XY_W'(x);
    it.oy   = crfg_pkg::XY_W'(y);
    it.w    = crfg_pkg::EXT_W'(w);
    it.h    = crfg_pkg::EXT_W'(h);
    it.row  = crfg_pkg::RC_W'(r);
    it.col  = crfg_pkg::RC_W'(c);
    return it;
  endfunction

  function automatic grid_item_t random_item();
    grid_item_t it;
    int pick;
    // full-range fields first, so unused fields toggle as well
    it.func = crfg_pkg::FUNC_NOP;
    it.ox   = crfg_pkg::XY_W'($urandom);
    it.oy   = crfg_pkg::XY_W'($urandom);
    it.w    = crfg_pkg::EXT_W'($urandom);
    it.h    = crfg_pkg::EXT_W'($urandom);
    it.row  = crfg_pkg::RC_W'($urandom);
    it.col  = crfg_pkg::RC_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 52) begin
      it.func = crfg_pkg::FUNC_FILL;
      if ($urandom_range(99) < 85) begin
        it.ox = crfg_pkg::XY_W'(int'($urandom_range(GRID_COLS + 6)) - 8);
        it.oy = crfg_pkg::XY_W'(int'($urandom_range(GRID_ROWS + 5)) - 5);
        it.w  = crfg_pkg::EXT_W'($urandom_range(14));
        it.h  = crfg_pkg::EXT_W'($urandom_range(8));
      end
    end else if (pick < 89) begin
      it.func = crfg_pkg::FUNC_READ;
      if ($urandom_range(99) < 85) begin
        it.row = crfg_pkg::RC_W'($urandom_range(GRID_ROWS + 2));
        it.col = crfg_pkg::RC_W'($urandom_range(GRID_COLS + 4));
      end
    end else if (pick < 92) begin
      it.func = crfg_pkg::FUNC_CLEAR;
    end
    return it;
  endfunction

  // starts at the falling edge after the previous accept; valid stays high between items unless idle gaps are drawn
  task automatic send_item(grid_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= it.func;
    in_origin_x   <= it.ox;
    in_origin_y   <= it.oy;
    in_box_width  <= it.w;
    in_box_height <= it.h;
    in_read_row   <= it.row;
    in_read_col   <= it.col;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
  endtask

  initial begin : stimulus
    int phase, n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // background kinds on an empty grid
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 1, 1));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 1, 0));
    // boxes that clip to nothing
    send_item(make_item(crfg_pkg::FUNC_FILL, -128, -128, 127, 127, 63, 63));
    send_item(make_item(crfg_pkg::FUNC_FILL, 127, 127, 127, 127, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_FILL, 0, 0, 0, 5, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_FILL, -1, 3, 1, 4, 0, 0));
    // negative origin on both axes at once
    send_item(make_item(crfg_pkg::FUNC_FILL, -3, -2, 5, 4, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 20, 1));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 20, 2));
    // cut at the last column and top row
    send_item(make_item(crfg_pkg::FUNC_FILL, 48, 19, 127, 127, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 0, 50));
    // reads outside the grid
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 21, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 0, 51));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 63, 63));
    send_item(make_item(crfg_pkg::FUNC_NOP, -1, -1, 127, 127, 63, 63));
    send_item(make_item(crfg_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 20, 1));
    send_item(make_item(crfg_pkg::FUNC_FILL, 0, 0, 127, 127, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 10, 25));
    send_item(make_item(crfg_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_FILL, 50, 20, 1, 1, 0, 0));
    send_item(make_item(crfg_pkg::FUNC_READ, 0, 0, 0, 0, 0, 50));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (n = 0; n < 190; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (phase == 0 && n == 60) holds_requested++;
        send_item(random_item());
      end
    end

    @(negedge clk);
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
